>>> src/bdlp_pkg.sv
// bdlp_pkg: shared types and codes for the button debounce block
// phase codes, event codes, register indexes and the configuration struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bdlp_pkg;

  localparam int TIME_W  = 32;
  localparam int PHASE_W = 2;
  localparam int EVENT_W = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE     = 2'd0;
  localparam logic [PHASE_W-1:0] PH_DEBOUNCE = 2'd1;
  localparam logic [PHASE_W-1:0] PH_PRESSED  = 2'd2;
  localparam logic [PHASE_W-1:0] PH_REPEAT   = 2'd3;

  // event codes
  localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
  localparam logic [EVENT_W-1:0] EV_PRESS  = 2'd1;
  localparam logic [EVENT_W-1:0] EV_LONG   = 2'd2;
  localparam logic [EVENT_W-1:0] EV_REPEAT = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_EN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_EN       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_EN     = 3'd5;

  // register reset values
  localparam logic [TIME_W-1:0] DEBOUNCE_MS_RST   = 32'd20;
  localparam logic [TIME_W-1:0] LONG_PRESS_MS_RST = 32'd1000;
  localparam logic [TIME_W-1:0] REPEAT_MS_RST     = 32'd200;

  typedef struct packed {
    logic [TIME_W-1:0] debounce_ms;
    logic [TIME_W-1:0] long_press_ms;
    logic [TIME_W-1:0] repeat_ms;
    logic              press_event_enable;
    logic              long_event_enable;
    logic              repeat_event_enable;
  } bdlp_cfg_t;

endpackage

`default_nettype wire

>>> src/bdlp_if.sv
// bdlp_if: valid/ready channel interfaces for polls and results
// depends on bdlp_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface bdlp_in_if
  import bdlp_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              pin_level;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, output pin_level, output now_ms, input ready);
  modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

interface bdlp_out_if
  import bdlp_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [EVENT_W-1:0] event_code;
  logic [PHASE_W-1:0] fsm_state;

  modport source (output valid, output event_code, output fsm_state, input ready);
  modport sink   (input valid, input event_code, input fsm_state, output ready);
endinterface

`default_nettype wire

>>> src/bdlp_cfg.sv
// bdlp_cfg: timing and event enable registers behind the write port
// depends on bdlp_pkg
`timescale 1ns / 1ps
`default_nettype none

module bdlp_cfg
  import bdlp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output bdlp_cfg_t                  cfg
);

  bdlp_cfg_t cfg_r;
  bdlp_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE_MS:   cfg_nxt.debounce_ms         = cfg_wdata[TIME_W-1:0];
        REG_LONG_PRESS_MS: cfg_nxt.long_press_ms       = cfg_wdata[TIME_W-1:0];
        REG_REPEAT_MS:     cfg_nxt.repeat_ms           = cfg_wdata[TIME_W-1:0];
        REG_PRESS_EN:      cfg_nxt.press_event_enable  = cfg_wdata[0];
        REG_LONG_EN:       cfg_nxt.long_event_enable   = cfg_wdata[0];
        REG_REPEAT_EN:     cfg_nxt.repeat_event_enable = cfg_wdata[0];
        default: begin
          // unused index, write dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms         <= DEBOUNCE_MS_RST;
      cfg_r.long_press_ms       <= LONG_PRESS_MS_RST;
      cfg_r.repeat_ms           <= REPEAT_MS_RST;
      cfg_r.press_event_enable  <= 1'b0;
      cfg_r.long_event_enable   <= 1'b0;
      cfg_r.repeat_event_enable <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> src/bdlp_core.sv
// bdlp_core: four-phase debounce machine with its timestamp register
// one poll per enabled cycle; depends on bdlp_pkg
`timescale 1ns / 1ps
`default_nettype none

module bdlp_core
  import bdlp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step_en,
  input  wire logic               pin_level,
  input  wire logic [TIME_W-1:0]  now_ms,
  input  wire bdlp_cfg_t          cfg,
  output logic      [EVENT_W-1:0] event_code,
  output logic      [PHASE_W-1:0] fsm_state
);

  logic [PHASE_W-1:0] phase_r;
  logic [PHASE_W-1:0] phase_nxt;
  logic [TIME_W-1:0]  mark_r;
  logic [TIME_W-1:0]  mark_nxt;
  logic [TIME_W-1:0]  elapsed;
  logic               held;
  logic [EVENT_W-1:0] ev;

  assign held    = ~pin_level;
  // modulo 2^32 interval
  assign elapsed = now_ms - mark_r;

  always_comb begin
    phase_nxt = phase_r;
    mark_nxt  = mark_r;
    ev        = EV_NONE;
    case (phase_r)
      PH_IDLE: begin
        if (held) begin
          phase_nxt = PH_DEBOUNCE;
          mark_nxt  = now_ms;
        end
      end
      PH_DEBOUNCE: begin
        if (elapsed > cfg.debounce_ms) begin
          if (held) begin
            phase_nxt = PH_PRESSED;
            mark_nxt  = now_ms;
            if (cfg.press_event_enable) ev = EV_PRESS;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_PRESSED: begin
        if (!held) begin
          phase_nxt = PH_IDLE;
        end else if (elapsed > cfg.long_press_ms) begin
          phase_nxt = PH_REPEAT;
          mark_nxt  = now_ms;
          if (cfg.long_event_enable) ev = EV_LONG;
        end
      end
      default: begin
        if (!held) begin
          phase_nxt = PH_IDLE;
        end else if (elapsed > cfg.repeat_ms && cfg.repeat_event_enable) begin
          mark_nxt = now_ms;
          ev       = EV_REPEAT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      mark_r  <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      mark_r  <= mark_nxt;
    end
  end

  assign event_code = ev;
  assign fsm_state  = phase_nxt;

endmodule

`default_nettype wire

>>> src/button_debounce_long_press_repeat.sv
// button_debounce_long_press_repeat: debouncer with long-press and auto-repeat events
// path: accepted poll passes the input register, then the result register, to result valid
// one poll per cycle unless out_ch stalls; the phase/timestamp update is combinational
// reset: synchronous active-low rst_n empties both stages, sets idle phase, zero timestamp
// and register values 20, 1000, 200 ms with all events disabled
// depends on bdlp_pkg, bdlp_if, bdlp_cfg, bdlp_core
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_long_press_repeat
  import bdlp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  bdlp_in_if.sink                    in_ch,
  bdlp_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  bdlp_cfg_t          cfg;

  logic               s1_valid_r;
  logic               s1_pin_r;
  logic [TIME_W-1:0]  s1_now_r;
  logic               s1_adv;

  logic               out_valid_r;
  logic [EVENT_W-1:0] out_event_r;
  logic [PHASE_W-1:0] out_state_r;
  logic               out_free;

  logic [EVENT_W-1:0] core_event;
  logic [PHASE_W-1:0] core_state;

  bdlp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // result register frees up when empty or taken this cycle
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;

  bdlp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (s1_adv),
    .pin_level  (s1_pin_r),
    .now_ms     (s1_now_r),
    .cfg        (cfg),
    .event_code (core_event),
    .fsm_state  (core_state)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_pin_r <= in_ch.pin_level;
      s1_now_r <= in_ch.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_event_r <= core_event;
      out_state_r <= core_state;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.event_code = out_event_r;
  assign out_ch.fsm_state  = out_state_r;

endmodule

`default_nettype wire
